FILE: rtl/pms_pkg.sv
// Shared types and codes for the Post machine stepper.
package pms_pkg;

    // Function select of an input item
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_STEP   = 1'b1;

    // Instruction operation codes
    localparam logic [2:0] OP_SET   = 3'd0;
    localparam logic [2:0] OP_CLEAR = 3'd1;
    localparam logic [2:0] OP_LEFT  = 3'd2;
    localparam logic [2:0] OP_RIGHT = 3'd3;
    localparam logic [2:0] OP_CHECK = 3'd4;
    localparam logic [2:0] OP_HALT  = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_HALT = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    // Input item
    typedef struct packed {
        logic       func;
        logic [2:0] op_code;
        logic [8:0] target_one;
        logic [8:0] target_two;
    } t_in;

    // Result item
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] counter_out;
        logic [9:0] head_out;
        logic       cell_out;
        logic [8:0] program_length;
    } t_out;

    // Program store entry
    typedef struct packed {
        logic [2:0] op_code;
        logic [8:0] target_one;
        logic [8:0] target_two;
    } t_instr;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic clear_wr;
        logic decode;
        logic load_cell;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic move;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/pms_ram.sv
// Generic simple dual-port RAM with registered read.
module pms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pms_ctrl.sv
// Controller state machine for the Post machine stepper.
module pms_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pms_pkg::t_dp_sts i_sts,
    output pms_pkg::t_dp_cmd o_cmd
);

    pms_pkg::t_state r_state;
    pms_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pms_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pms_pkg::S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = pms_pkg::S_IDLE;
                end
            end
            pms_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pms_pkg::S_DECODE;
                end
            end
            pms_pkg::S_DECODE: begin
                if (i_sts.move) begin
                    n_state = pms_pkg::S_LOAD;
                end else if (i_sts.out_free) begin
                    n_state = pms_pkg::S_IDLE;
                end else begin
                    n_state = pms_pkg::S_EMIT;
                end
            end
            pms_pkg::S_LOAD: begin
                if (i_sts.out_free) begin
                    n_state = pms_pkg::S_IDLE;
                end else begin
                    n_state = pms_pkg::S_EMIT;
                end
            end
            pms_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = pms_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pms_pkg::S_CLEAR;
            end
        endcase
    end

    // Commands per state
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        case (r_state)
            pms_pkg::S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
            end
            pms_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            pms_pkg::S_DECODE: begin
                o_cmd.decode   = 1'b1;
                o_cmd.load_out = !i_sts.move && i_sts.out_free;
            end
            pms_pkg::S_LOAD: begin
                o_cmd.load_cell = 1'b1;
                o_cmd.load_out  = i_sts.out_free;
            end
            pms_pkg::S_EMIT: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/pms_dp.sv
// Datapath of the Post machine stepper: program store, tape, registers, result stage.
module pms_dp #(
    parameter int TAPE_CELLS = 1024,
    parameter int PROG_DEPTH = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pms_pkg::t_dp_cmd i_cmd,
    output pms_pkg::t_dp_sts o_sts,
    input  pms_pkg::t_in     i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pms_pkg::t_out    o_out_data
);

    localparam int HW      = $clog2(TAPE_CELLS);
    localparam int PW      = $clog2(PROG_DEPTH);
    localparam int CW      = $clog2(PROG_DEPTH + 1);
    localparam int INSTR_W = $bits(pms_pkg::t_instr);
    localparam logic [HW-1:0] HEAD_LAST = HW'(TAPE_CELLS - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(PROG_DEPTH);

    pms_pkg::t_in   r_item;
    logic [PW-1:0]  r_pc,      n_pc;
    logic [HW-1:0]  r_head,    n_head;
    logic           r_cell,    n_cell;
    logic [CW-1:0]  r_count,   n_count;
    logic           r_invalid, n_invalid;
    logic [1:0]     r_status,  n_status;
    logic [HW-1:0]  r_clr_addr;
    logic           r_out_valid;
    pms_pkg::t_out  r_out_data, n_out_data;

    logic [INSTR_W-1:0] w_prog_rdata;
    pms_pkg::t_instr    w_instr;
    pms_pkg::t_instr    w_prog_wdata;
    logic               w_prog_we;
    logic [0:0]         w_tape_rdata;
    logic               w_tape_we;
    logic [HW-1:0]      w_tape_waddr;
    logic [0:0]         w_tape_wdata;
    logic               w_exec_we;
    logic               w_exec_bit;
    logic               w_exec;
    logic [8:0]         w_target;
    logic               w_full;
    logic               w_pre_err;
    logic               w_move;
    logic [31:0]        w_pc32;
    logic [31:0]        w_head32;
    logic [31:0]        w_count32;

    // Program store
    assign w_prog_wdata = '{op_code:    r_item.op_code,
                            target_one: r_item.target_one,
                            target_two: r_item.target_two};

    pms_ram #(
        .WIDTH (INSTR_W),
        .DEPTH (PROG_DEPTH)
    ) u_prog_ram (
        .i_clk   (i_clk),
        .i_we    (w_prog_we),
        .i_waddr (r_count[PW-1:0]),
        .i_wdata (w_prog_wdata),
        .i_raddr (r_pc),
        .o_rdata (w_prog_rdata)
    );

    assign w_instr = w_prog_rdata;

    // Tape: the clearing pass owns the write port after reset
    assign w_tape_we       = i_cmd.clear_wr || w_exec_we;
    assign w_tape_waddr    = i_cmd.clear_wr ? r_clr_addr : r_head;
    assign w_tape_wdata[0] = !i_cmd.clear_wr && w_exec_bit;

    pms_ram #(
        .WIDTH (1),
        .DEPTH (TAPE_CELLS)
    ) u_tape_ram (
        .i_clk   (i_clk),
        .i_we    (w_tape_we),
        .i_waddr (w_tape_waddr),
        .i_wdata (w_tape_wdata),
        .i_raddr (n_head),
        .o_rdata (w_tape_rdata)
    );

    // Conditions of the held item
    assign w_full    = (r_count == COUNT_MAX);
    assign w_pre_err = r_invalid || (r_count == '0) || (32'(r_pc) >= 32'(r_count));
    assign w_move    = (r_item.func == pms_pkg::FUNC_STEP) && !w_pre_err &&
                       ((w_instr.op_code == pms_pkg::OP_LEFT) ||
                        (w_instr.op_code == pms_pkg::OP_RIGHT));

    // Execute the held item
    always_comb begin
        n_pc       = r_pc;
        n_head     = r_head;
        n_cell     = r_cell;
        n_count    = r_count;
        n_invalid  = r_invalid;
        n_status   = r_status;
        w_prog_we  = 1'b0;
        w_exec_we  = 1'b0;
        w_exec_bit = 1'b0;
        w_exec     = 1'b0;
        w_target   = w_instr.target_one;
        if (i_cmd.decode) begin
            if (r_item.func == pms_pkg::FUNC_APPEND) begin
                if (w_full) begin
                    n_status = pms_pkg::ST_FULL;
                end else begin
                    w_prog_we = 1'b1;
                    n_count   = r_count + 1'b1;
                    n_status  = pms_pkg::ST_OK;
                end
            end else if (w_pre_err) begin
                n_status = pms_pkg::ST_ERR;
            end else begin
                case (w_instr.op_code)
                    pms_pkg::OP_SET: begin
                        w_exec_we  = 1'b1;
                        w_exec_bit = 1'b1;
                        n_cell     = 1'b1;
                        w_exec     = 1'b1;
                    end
                    pms_pkg::OP_CLEAR: begin
                        w_exec_we  = 1'b1;
                        w_exec_bit = 1'b0;
                        n_cell     = 1'b0;
                        w_exec     = 1'b1;
                    end
                    pms_pkg::OP_LEFT: begin
                        n_head = (r_head == '0) ? HEAD_LAST : r_head - 1'b1;
                        w_exec = 1'b1;
                    end
                    pms_pkg::OP_RIGHT: begin
                        n_head = (r_head == HEAD_LAST) ? '0 : r_head + 1'b1;
                        w_exec = 1'b1;
                    end
                    pms_pkg::OP_CHECK: begin
                        w_target = r_cell ? w_instr.target_one : w_instr.target_two;
                        w_exec   = 1'b1;
                    end
                    pms_pkg::OP_HALT: begin
                        n_status = pms_pkg::ST_HALT;
                    end
                    default: begin
                        n_status = pms_pkg::ST_OK;
                    end
                endcase
                // Jump, or flag the counter when the target leaves the program
                if (w_exec) begin
                    if ((w_target == '0) || (32'(w_target) > 32'(r_count))) begin
                        n_invalid = 1'b1;
                        n_status  = pms_pkg::ST_ERR;
                    end else begin
                        n_pc     = PW'(w_target - 9'd1);
                        n_status = pms_pkg::ST_OK;
                    end
                end
            end
        end
        if (i_cmd.load_cell) begin
            n_cell = w_tape_rdata[0];
        end
    end

    // Build the result from the updated machine state
    assign w_pc32    = 32'(n_pc);
    assign w_head32  = 32'(n_head);
    assign w_count32 = 32'(n_count);

    always_comb begin
        n_out_data.status         = n_status;
        n_out_data.counter_out    = w_pc32[7:0];
        n_out_data.head_out       = w_head32[9:0];
        n_out_data.cell_out       = n_cell;
        n_out_data.program_length = w_count32[8:0];
    end

    // Machine state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_head      <= '0;
            r_cell      <= 1'b0;
            r_count     <= '0;
            r_invalid   <= 1'b0;
            r_status    <= pms_pkg::ST_OK;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc      <= n_pc;
            r_head    <= n_head;
            r_cell    <= n_cell;
            r_count   <= n_count;
            r_invalid <= n_invalid;
            r_status  <= n_status;
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.load_out) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_sts.clear_last = (r_clr_addr == HEAD_LAST);
    assign o_sts.move       = w_move;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/post_machine_step_top.sv
// Top level of the Post machine stepper on a circular bit tape.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------
//   in      | input     | i_in_valid / o_in_ready   | i_in_data  (t_in)
//   out     | output    | o_out_valid / i_out_ready | o_out_data (t_out)
//
// An append, an error or halt result and a set, clear or check step pass through
// the transfer state, then an execute state on the program memory read data, at
// whose end the result register is loaded if it is free; left and right add a
// load state, as the tape memory is read again at the new head for the cell under
// it. After reset the tape is cleared one cell a cycle, with o_in_ready low until
// the last cell is written. A result held in the output register does not block
// the next transfer; the block waits in its final cycle only while it is full.
module post_machine_step_top #(
    parameter int TAPE_CELLS = 1024,
    parameter int PROG_DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pms_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pms_pkg::t_out o_out_data
);

    pms_pkg::t_dp_cmd w_cmd;
    pms_pkg::t_dp_sts w_sts;

    pms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pms_dp #(
        .TAPE_CELLS (TAPE_CELLS),
        .PROG_DEPTH (PROG_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/pms_checker.sv
// Port-level checks for the Post machine stepper, bound to the top level.
module pms_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input pms_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input pms_pkg::t_out o_out_data
);

    // Hold a stalled result unchanged
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

    // Hold a waiting input item unchanged until its transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_in_data)))
        else $error("input item dropped or changed before its transfer");

    // Drop ready after each input transfer while the item executes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again while an item executes");

    // Reset empties the result stage and starts the tape clearing pass
    assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_ready))
        else $error("reset left the block ready or a result valid");

    // A halt result never shows a program length of zero unless its counter is zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == pms_pkg::ST_HALT))
            |-> (o_out_data.program_length != '0 || o_out_data.counter_out == '0))
        else $error("halt reported with no program loaded");

endmodule

bind post_machine_step_top pms_checker u_pms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
